// ----- hdl/b64d_pkg.sv -----
package b64d_pkg;

	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;

	localparam logic [5:0] SEXTET_LO_BASE  = 6'd26;
	localparam logic [5:0] SEXTET_DIG_BASE = 6'd52;
	localparam logic [5:0] SEXTET_62       = 6'd62;
	localparam logic [5:0] SEXTET_63       = 6'd63;

	localparam int RES_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEN  = 2'd1,
		ST_BAD_CHAR = 2'd2,
		ST_TAIL     = 2'd3
	} b64d_status_t;

	typedef struct packed {
		logic       is_pad;
		logic       is_sym;
		logic [5:0] sextet;
		logic       last;
	} b64d_item_t;

	typedef struct packed {
		logic         byte_valid;
		logic [7:0]   data_byte;
		logic         done_res;
		b64d_status_t status;
	} b64d_result_t;

endpackage

// ----- hdl/b64d_queue.sv -----
module b64d_queue #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == DEPTH_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- hdl/b64d_front.sv -----
module b64d_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           char_code,
	input  logic                 last_char,
	output logic                 item_push,
	output b64d_pkg::b64d_item_t item_out,
	input  logic                 item_full
);
	import b64d_pkg::*;

	logic       valid_s1;
	b64d_item_t item_s1;
	b64d_item_t item_d;
	logic [7:0] diff;
	logic       accept;

	always_comb begin
		item_d        = '0;
		item_d.last   = last_char;
		item_d.is_pad = (char_code == CH_PAD);
		diff          = '0;
		if (char_code >= CH_UP_A && char_code <= CH_UP_Z) begin
			diff          = char_code - CH_UP_A;
			item_d.is_sym = 1'b1;
			item_d.sextet = diff[5:0];
		end else if (char_code >= CH_LO_A && char_code <= CH_LO_Z) begin
			diff          = char_code - CH_LO_A;
			item_d.is_sym = 1'b1;
			item_d.sextet = SEXTET_LO_BASE + diff[5:0];
		end else if (char_code >= CH_DIG_0 && char_code <= CH_DIG_9) begin
			diff          = char_code - CH_DIG_0;
			item_d.is_sym = 1'b1;
			item_d.sextet = SEXTET_DIG_BASE + diff[5:0];
		end else if (char_code == CH_DASH || char_code == CH_PLUS) begin
			item_d.is_sym = 1'b1;
			item_d.sextet = SEXTET_62;
		end else if (char_code == CH_UNDER || char_code == CH_SLASH) begin
			item_d.is_sym = 1'b1;
			item_d.sextet = SEXTET_63;
		end
	end

	assign full      = valid_s1 && item_full;
	assign accept    = push && !full;
	assign item_push = valid_s1;
	assign item_out  = item_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!item_full) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

// ----- hdl/b64d_back.sv -----
module b64d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  b64d_pkg::b64d_item_t   item_in,
	output logic                   item_pop,
	output logic                   res_push,
	output b64d_pkg::b64d_result_t res_out,
	input  logic                   res_full
);
	import b64d_pkg::*;

	logic [5:0]   lb_q;
	logic [2:0]   lc_q;
	logic [1:0]   phase_q;
	logic [1:0]   pad_q;
	logic         err_q;
	logic [5:0]   lb_n;
	logic [2:0]   lc_n;
	logic [1:0]   phase_n;
	logic [1:0]   pad_n;
	logic         err_n;
	logic         take;
	b64d_result_t res;

	assign take     = item_valid && !res_full;
	assign item_pop = take;
	assign res_push = take;
	assign res_out  = res;

	always_comb begin
		logic [11:0] acc;
		logic [3:0]  cnt;
		logic [2:0]  rem;
		acc        = {lb_q, item_in.sextet};
		cnt        = {1'b0, lc_q} + 4'd6;
		rem        = (cnt >= 4'd8) ? 3'(cnt - 4'd8) : cnt[2:0];
		lb_n       = lb_q;
		lc_n       = lc_q;
		phase_n    = phase_q;
		pad_n      = pad_q;
		err_n      = err_q;
		res        = '0;
		res.status = ST_OK;
		if (item_in.is_pad) begin
			pad_n = pad_q + 2'd1;
		end else begin
			if (pad_q != 2'd0) begin
				phase_n = phase_q + pad_q;
				pad_n   = 2'd0;
				err_n   = 1'b1;
			end
			phase_n = phase_n + 2'd1;
			if (item_in.is_sym) begin
				if (cnt >= 4'd8 && !err_n) begin
					res.byte_valid = 1'b1;
					case (rem)
						3'd2:    res.data_byte = acc[9:2];
						3'd4:    res.data_byte = acc[11:4];
						default: res.data_byte = acc[7:0];
					endcase
				end
				case (rem)
					3'd2:    lb_n = {4'b0, acc[1:0]};
					3'd4:    lb_n = {2'b0, acc[3:0]};
					3'd6:    lb_n = acc[5:0];
					default: lb_n = '0;
				endcase
				lc_n = rem;
			end else begin
				err_n = 1'b1;
			end
		end
		if (item_in.last) begin
			res.done_res = 1'b1;
			if (phase_n == 2'd1) begin
				res.status = ST_BAD_LEN;
			end else if (err_n) begin
				res.status = ST_BAD_CHAR;
			end else if (lc_n != 3'd0 && lb_n != 6'd0) begin
				res.status = ST_TAIL;
			end
			lb_n    = '0;
			lc_n    = '0;
			phase_n = '0;
			pad_n   = '0;
			err_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q    <= '0;
			lc_q    <= '0;
			phase_q <= '0;
			pad_q   <= '0;
			err_q   <= 1'b0;
		end else if (take) begin
			lb_q    <= lb_n;
			lc_q    <= lc_n;
			phase_q <= phase_n;
			pad_q   <= pad_n;
			err_q   <= err_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res.status != ST_OK) |-> res.done_res)
		else $error("status reported without done");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item_in.last) |=>
		(lc_q == 3'd0 && lb_q == 6'd0 && phase_q == 2'd0 && pad_q == 2'd0 && !err_q))
		else $error("state not cleared after last character");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res.byte_valid) |-> (!err_q && pad_q == 2'd0 && item_in.is_sym))
		else $error("byte emitted after error or padding");

	a_count_even: assert property (@(posedge clk) disable iff (!arst_n)
		!lc_q[0])
		else $error("leftover count odd");
`endif

endmodule

// ----- hdl/base64url_strict_decoder.sv -----
// Channel   Handshake              Payload
// input     push / full            char_code[7:0], last_char
// result    empty / pop            byte_valid, data_byte[7:0], done_res, status[1:0]
//
// One character accepted per cycle while full is low; one result per character.
// From acceptance to the result showing (empty low), a character passes the
// classify register, the item queue and the result buffer.
// Either side may stall independently; the item queue (QUEUE_DEPTH) and the
// two-entry result buffer absorb the difference. Reset clears all control state (stored data is not reset), no sweep.
module base64url_strict_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       empty,
	input  logic       pop,
	output logic       byte_valid,
	output logic [7:0] data_byte,
	output logic       done_res,
	output logic [1:0] status
);
	import b64d_pkg::*;

	localparam int ITEM_W = $bits(b64d_item_t);
	localparam int RES_W  = $bits(b64d_result_t);

	logic         fq_push;
	logic         fq_full;
	b64d_item_t   fq_wr;
	b64d_item_t   fq_rd;
	logic         fq_empty;
	logic         fq_pop;
	logic         rb_push;
	logic         rb_full;
	b64d_result_t rb_wr;
	b64d_result_t rb_rd;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_code (char_code),
		.last_char (last_char),
		.item_push (fq_push),
		.item_out  (fq_wr),
		.item_full (fq_full)
	);

	b64d_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_item_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fq_push),
		.wr_data (fq_wr),
		.full    (fq_full),
		.pop     (fq_pop),
		.rd_data (fq_rd),
		.empty   (fq_empty)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!fq_empty),
		.item_in    (fq_rd),
		.item_pop   (fq_pop),
		.res_push   (rb_push),
		.res_out    (rb_wr),
		.res_full   (rb_full)
	);

	b64d_queue #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_buffer (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (rb_push),
		.wr_data (rb_wr),
		.full    (rb_full),
		.pop     (pop),
		.rd_data (rb_rd),
		.empty   (empty)
	);

	assign byte_valid = rb_rd.byte_valid;
	assign data_byte  = rb_rd.data_byte;
	assign done_res   = rb_rd.done_res;
	assign status     = rb_rd.status;

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import b64d_pkg::*;

	localparam int IDLE_PCT     = 24;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 12;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic [7:0] char_code = 8'h00;
	logic       last_char = 1'b0;
	logic       pop       = 1'b0;
	logic       full;
	logic       empty;
	logic       byte_valid;
	logic [7:0] data_byte;
	logic       done_res;
	logic [1:0] status;

	int idle_pct = IDLE_PCT;

	b64d_result_t decoded_q[$];
	b64d_result_t decoded_got;
	b64d_result_t decoded_want;

	logic [5:0] tail_bits = '0;
	logic [3:0] tail_cnt  = '0;
	logic [1:0] len_phase = '0;
	logic [1:0] pad_run   = '0;
	logic       bad_char  = 1'b0;

	int unsigned chars_sent   = 0;
	int unsigned texts_sent   = 0;
	int unsigned bytes_seen   = 0;
	int unsigned errors       = 0;
	int unsigned stall_cycles = 0;
	int unsigned status_seen[4] = '{0, 0, 0, 0};

	base64url_strict_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_code (char_code),
		.last_char (last_char),
		.empty     (empty),
		.pop       (pop),
		.byte_valid(byte_valid),
		.data_byte (data_byte),
		.done_res  (done_res),
		.status    (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic sextet_lookup(input logic [7:0] c, output logic [5:0] v);
		v = 6'd0;
		sextet_lookup = 1'b1;
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			v = 6'(c - CH_UP_A);
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			v = SEXTET_LO_BASE + 6'(c - CH_LO_A);
		end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
			v = SEXTET_DIG_BASE + 6'(c - CH_DIG_0);
		end else if (c == CH_DASH || c == CH_PLUS) begin
			v = SEXTET_62;
		end else if (c == CH_UNDER || c == CH_SLASH) begin
			v = SEXTET_63;
		end else begin
			sextet_lookup = 1'b0;
		end
	endfunction

	function automatic b64d_result_t decode_char(input logic [7:0] c, input logic l);
		b64d_result_t r;
		logic [5:0]   v;
		logic [11:0]  acc;
		logic [3:0]   cnt;
		r.byte_valid = 1'b0;
		r.data_byte  = 8'h00;
		r.done_res   = 1'b0;
		r.status     = ST_OK;
		if (c == CH_PAD) begin
			pad_run = pad_run + 2'd1;
		end else begin
			if (pad_run != 2'd0) begin
				len_phase = len_phase + pad_run;
				pad_run   = 2'd0;
				bad_char  = 1'b1;
			end
			len_phase = len_phase + 2'd1;
			if (sextet_lookup(c, v)) begin
				acc = {tail_bits, v};
				cnt = tail_cnt + 4'd6;
				if (cnt >= 4'd8) begin
					cnt = cnt - 4'd8;
					if (!bad_char) begin
						r.byte_valid = 1'b1;
						r.data_byte  = 8'(acc >> cnt);
					end
				end
				tail_bits = 6'(acc & ((12'd1 << cnt) - 12'd1));
				tail_cnt  = cnt;
			end else begin
				bad_char = 1'b1;
			end
		end
		if (l) begin
			r.done_res = 1'b1;
			if (len_phase == 2'd1)
				r.status = ST_BAD_LEN;
			else if (bad_char)
				r.status = ST_BAD_CHAR;
			else if (tail_cnt != 4'd0 && tail_bits != 6'd0)
				r.status = ST_TAIL;
			tail_bits = '0;
			tail_cnt  = '0;
			len_phase = '0;
			pad_run   = '0;
			bad_char  = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [7:0] sym_char(input logic [5:0] v);
		logic alt;
		alt = 1'($urandom_range(0, 1));
		if (v < SEXTET_LO_BASE)
			return CH_UP_A + 8'(v);
		else if (v < SEXTET_DIG_BASE)
			return CH_LO_A + 8'(v - SEXTET_LO_BASE);
		else if (v < SEXTET_62)
			return CH_DIG_0 + 8'(v - SEXTET_DIG_BASE);
		else if (v == SEXTET_62)
			return alt ? CH_PLUS : CH_DASH;
		else
			return alt ? CH_SLASH : CH_UNDER;
	endfunction

	task automatic send_char(input logic [7:0] c, input logic l);
		while ($urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		char_code <= c;
		last_char <= l;
		do @(posedge clk); while (full);
		decoded_q = {decoded_q, decode_char(c, l)};
		chars_sent++;
		if (l)
			texts_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_seq(input logic [7:0] seq[$]);
		for (int i = 0; i < seq.size(); i++)
			send_char(seq[i], i == seq.size() - 1);
	endtask

	task automatic send_wellformed();
		int          n;
		logic [5:0]  v;
		logic [7:0]  seq[$];
		n = $urandom_range(0, 16);
		if (n % 4 == 1)
			n++;
		for (int i = 0; i < n; i++) begin
			v = 6'($urandom);
			if (i == n - 1 && $urandom_range(0, 4) != 0) begin
				if (n % 4 == 2)
					v[3:0] = 4'd0;
				else if (n % 4 == 3)
					v[1:0] = 2'd0;
			end
			seq = {seq, sym_char(v)};
		end
		if (n == 0) begin
			repeat ($urandom_range(1, 4)) seq = {seq, CH_PAD};
		end else if ($urandom_range(0, 1)) begin
			while (seq.size() % 4 != 0)
				seq = {seq, CH_PAD};
		end
		send_seq(seq);
	endtask

	task automatic send_broken();
		int          r;
		logic [7:0]  seq[$];
		repeat ($urandom_range(1, 10)) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				seq = {seq, sym_char(6'($urandom))};
			else if (r < 8)
				seq = {seq, CH_PAD};
			else
				seq = {seq, 8'($urandom)};
		end
		send_seq(seq);
	endtask

	task automatic test_directed();
		send_text("Zg==");
		send_text("-_+/");
		send_text("A");
		send_text("AB");
		send_text("=");
		send_text("Z=g=");
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_text("az");
	endtask

	task automatic test_wellformed_stream();
		while (chars_sent < 900) begin
			if ($urandom_range(0, 99) < 85)
				send_wellformed();
			else
				send_broken();
		end
	endtask

	task automatic test_drain_pause();
		repeat (3) send_wellformed();
		push <= 1'b0;
		wait (decoded_q.size() == 0);
		@(posedge clk);
		repeat (3) send_wellformed();
	endtask

	task automatic test_broken_stream();
		while (chars_sent < 1350) begin
			if ($urandom_range(0, 99) < 70)
				send_broken();
			else
				send_wellformed();
		end
	endtask

	task automatic test_burst();
		idle_pct = 0;
		while (chars_sent < 1750) begin
			if ($urandom_range(0, 99) < 75)
				send_wellformed();
			else
				send_broken();
		end
		idle_pct = IDLE_PCT;
	endtask

	always @(posedge clk)
		pop <= ($urandom_range(0, 99) >= idle_pct);

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			decoded_got.byte_valid = byte_valid;
			decoded_got.data_byte  = data_byte;
			decoded_got.done_res   = done_res;
			decoded_got.status     = b64d_status_t'(status);
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected result valid=%0d byte=%02h done=%0d status=%0d",
					$time, byte_valid, data_byte, done_res, status);
				errors++;
			end else begin
				decoded_want = decoded_q.pop_front();
				if (decoded_got !== decoded_want) begin
					$display("%0t: expected v=%0d b=%02h d=%0d s=%0d, got v=%0d b=%02h d=%0d s=%0d",
						$time, decoded_want.byte_valid, decoded_want.data_byte,
						decoded_want.done_res, decoded_want.status,
						byte_valid, data_byte, done_res, status);
					errors++;
				end
			end
			if (byte_valid === 1'b1)
				bytes_seen++;
			if (done_res === 1'b1 && !$isunknown(status))
				status_seen[status]++;
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, stall_cycles);
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_wellformed_stream();
		test_drain_pause();
		test_broken_stream();
		test_burst();
		push <= 1'b0;
		wait (decoded_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d characters in %0d texts decoded, %0d bytes returned",
			chars_sent, texts_sent, bytes_seen);
		$display("texts ending ok %0d, bad length %0d, bad character %0d, nonzero tail %0d",
			status_seen[ST_OK], status_seen[ST_BAD_LEN], status_seen[ST_BAD_CHAR],
			status_seen[ST_TAIL]);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/b64d_pkg.sv
hdl/b64d_queue.sv
hdl/b64d_front.sv
hdl/b64d_back.sv
hdl/base64url_strict_decoder.sv
tb/tb_top.sv
